### rtl/core/w26_pkg.sv
package w26_pkg;

  // Payload and frame geometry.
  localparam int unsigned PAYLOAD_BITS = 24;
  localparam int unsigned HALF_BITS    = PAYLOAD_BITS / 2;
  localparam int unsigned FRAME_W      = PAYLOAD_BITS + 2;
  localparam int unsigned BIT_SEL_W    = $clog2(FRAME_W);

  // Register field widths.
  localparam int unsigned FRAME_BITS_W = 6;
  localparam int unsigned PULSE_LEN_W  = 9;
  localparam int unsigned BIT_GAP_W    = 15;
  localparam int unsigned MSG_GAP_W    = 16;
  localparam int unsigned REPEAT_W     = 16;
  localparam int unsigned TIMER_W      = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  // Result item width, padded to whole bytes.
  localparam int unsigned OUT_DATA_W   = 8;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_BITS = 3'd0,
    REG_PULSE_LEN  = 3'd1,
    REG_BIT_GAP    = 3'd2,
    REG_MSG_GAP    = 3'd3,
    REG_REPEAT     = 3'd4
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  // One classified item as it travels from the front queue to the back end.
  typedef struct packed {
    kind_t                kind;
    logic [FRAME_W-1:0]   frame;
  } entry_t;

endpackage

### rtl/core/w26_front.sv
module w26_front
  import w26_pkg::*;
#(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [PAYLOAD_BITS-1:0] in_tdata,
  input  logic                    in_tuser,
  output logic                    q_valid,
  output entry_t                  q_entry,
  input  logic                    q_pop
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  entry_t             q_mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push;
  entry_t             new_entry;
  logic               par_even;
  logic               par_odd;

  // The frame is built here, so the back end only selects stored bits.
  always_comb begin
    par_even = ^in_tdata[PAYLOAD_BITS-1:HALF_BITS];
    par_odd  = ~(^in_tdata[HALF_BITS-1:0]);
    new_entry.kind  = kind_t'(in_tuser);
    new_entry.frame = {par_even, in_tdata, par_odd};
  end

  assign in_tready = (count_r != CNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_entry   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_entry;
    end
  end

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("queue popped while empty");

endmodule

### rtl/core/w26_back.sv
module w26_back
  import w26_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  q_valid,
  input  entry_t                q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PULSE  = 2'd1,
    PH_BITGAP = 2'd2,
    PH_MSGGAP = 2'd3
  } phase_t;

  logic [FRAME_BITS_W-1:0] frame_bits_r;
  logic [PULSE_LEN_W-1:0]  pulse_len_r;
  logic [BIT_GAP_W-1:0]    bit_gap_r;
  logic [MSG_GAP_W-1:0]    msg_gap_r;
  logic [REPEAT_W-1:0]     repeat_count_r;

  phase_t                  phase_r, phase_nxt;
  logic [FRAME_W-1:0]      frame_r, frame_nxt;
  logic [FRAME_BITS_W-1:0] bit_index_r, bit_index_nxt;
  logic [TIMER_W-1:0]      tick_timer_r, tick_timer_nxt;
  logic [REPEAT_W-1:0]     repeats_left_r, repeats_left_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  logic [TIMER_W-1:0]      pulse_ticks, gap_ticks, msg_ticks;
  phase_t                  sf_phase;
  logic [TIMER_W-1:0]      sf_timer;
  logic [FRAME_BITS_W-1:0] sf_index;
  logic                    cur_bit;
  logic                    take;
  logic                    d0, d1, busy, done, rej;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_bits_r   <= FRAME_BITS_W'(26);
      pulse_len_r    <= PULSE_LEN_W'(100);
      bit_gap_r      <= BIT_GAP_W'(1000);
      msg_gap_r      <= MSG_GAP_W'(20000);
      repeat_count_r <= REPEAT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_BITS: frame_bits_r   <= cfg_wdata[FRAME_BITS_W-1:0];
        REG_PULSE_LEN:  pulse_len_r    <= cfg_wdata[PULSE_LEN_W-1:0];
        REG_BIT_GAP:    bit_gap_r      <= cfg_wdata[BIT_GAP_W-1:0];
        REG_MSG_GAP:    msg_gap_r      <= cfg_wdata[MSG_GAP_W-1:0];
        REG_REPEAT:     repeat_count_r <= cfg_wdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero duration lasts one tick.
  always_comb begin
    pulse_ticks = (pulse_len_r == '0) ? TIMER_W'(1) : TIMER_W'(pulse_len_r);
    gap_ticks   = (bit_gap_r == '0)   ? TIMER_W'(1) : TIMER_W'(bit_gap_r);
    msg_ticks   = (msg_gap_r == '0)   ? TIMER_W'(1) : TIMER_W'(msg_gap_r);
    if (frame_bits_r == '0) begin
      sf_phase = PH_MSGGAP;
      sf_timer = msg_ticks;
      sf_index = bit_index_r;
    end else begin
      sf_phase = PH_PULSE;
      sf_timer = pulse_ticks;
      sf_index = frame_bits_r - 1'b1;
    end
  end

  // Bits above the built frame are zero.
  assign cur_bit = (bit_index_r < FRAME_BITS_W'(FRAME_W)) ?
                   frame_r[bit_index_r[BIT_SEL_W-1:0]] : 1'b0;

  assign take = q_valid && (!out_tvalid_r || out_tready);

  always_comb begin
    phase_nxt        = phase_r;
    frame_nxt        = frame_r;
    bit_index_nxt    = bit_index_r;
    tick_timer_nxt   = tick_timer_r;
    repeats_left_nxt = repeats_left_r;
    d0   = 1'b1;
    d1   = 1'b1;
    busy = 1'b0;
    done = 1'b0;
    rej  = 1'b0;
    if (phase_r == PH_PULSE) begin
      d0 = cur_bit;
      d1 = ~cur_bit;
    end
    if (q_entry.kind == KIND_LOAD) begin
      busy = 1'b1;
      if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        frame_nxt        = q_entry.frame;
        repeats_left_nxt = (repeat_count_r == '0) ? REPEAT_W'(1) : repeat_count_r;
        phase_nxt        = sf_phase;
        tick_timer_nxt   = sf_timer;
        bit_index_nxt    = sf_index;
      end
    end else if (phase_r != PH_IDLE) begin
      busy = 1'b1;
      if (tick_timer_r > TIMER_W'(1)) begin
        tick_timer_nxt = tick_timer_r - 1'b1;
      end else begin
        unique case (phase_r)
          PH_PULSE: begin
            phase_nxt      = PH_BITGAP;
            tick_timer_nxt = gap_ticks;
          end
          PH_BITGAP: begin
            if (bit_index_r != '0) begin
              bit_index_nxt  = bit_index_r - 1'b1;
              phase_nxt      = PH_PULSE;
              tick_timer_nxt = pulse_ticks;
            end else begin
              phase_nxt      = PH_MSGGAP;
              tick_timer_nxt = msg_ticks;
            end
          end
          PH_MSGGAP: begin
            if (repeats_left_r > REPEAT_W'(1)) begin
              repeats_left_nxt = repeats_left_r - 1'b1;
              phase_nxt        = sf_phase;
              tick_timer_nxt   = sf_timer;
              bit_index_nxt    = sf_index;
            end else begin
              repeats_left_nxt = '0;
              phase_nxt        = PH_IDLE;
              tick_timer_nxt   = '0;
              bit_index_nxt    = '0;
              done             = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (take) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {3'b000, rej, done, busy, d1, d0};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      bit_index_r    <= '0;
      tick_timer_r   <= '0;
      repeats_left_r <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (take) begin
        phase_r        <= phase_nxt;
        bit_index_r    <= bit_index_nxt;
        tick_timer_r   <= tick_timer_nxt;
        repeats_left_r <= repeats_left_nxt;
      end
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_r     <= frame_nxt;
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign q_pop      = take;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_timer_r == '0 && repeats_left_r == '0))
    else $error("idle with live timer or repeat count");

  a_active_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (tick_timer_r != '0 && repeats_left_r != '0))
    else $error("active phase with empty timer or repeat count");

  a_flags_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tdata_r[3] || out_tdata_r[4])) |-> out_tdata_r[2])
    else $error("done or rejected flagged without busy");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && done) |=> (phase_r == PH_IDLE))
    else $error("done reported but send still active");

endmodule

### rtl/core/wiegand26_pulse_transmitter_top.sv
// Channel | Direction | Handshake            | Contents
// in_     | input     | in_tvalid/in_tready  | tuser: action, tdata: payload
// out_    | output    | out_tvalid/out_tready| tdata: line levels and status flags
// cfg_    | input     | cfg_we (no wait)     | cfg_index selects, cfg_wdata value
//
// One item is taken every clock cycle when the result side keeps up; a tick
// item advances the transmit state by one tick, a load starts a send if idle.
// An accepted item is stored in the front queue, and its result is then
// computed and registered in the result register.
// Reset (rst_n low at a clock edge) empties the queue, drops any pending
// result, returns the sender to idle and loads the register defaults.
module wiegand26_pulse_transmitter_top
  import w26_pkg::*;
#(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // Input items.
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [PAYLOAD_BITS-1:0] in_tdata,   // [23:0] payload
  input  logic                    in_tuser,   // [0] action: 0 tick, 1 load
  // Result items. A stalled result side fills the queue; in_tready falls
  // only when it is full.
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [OUT_DATA_W-1:0]   out_tdata,  // [0] data0_line, [1] data1_line,
                                              // [2] busy_res, [3] done_res,
                                              // [4] rejected, [7:5] zero
  // Configuration writes.
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  // The front end classifies each item and precomputes the parity-framed
  // word, so the back end sees ready-made frames.
  w26_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  // The back end runs the pulse, bit-gap and message-gap sequencer and
  // holds the result register.
  w26_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
